// ----- src/calu_pkg.sv -----
`default_nettype none

package calu_pkg;

    // Operation codes carried in the func field
    typedef enum logic [4:0] {
        FN_ADD   = 5'd0,
        FN_ADC   = 5'd1,
        FN_SUB   = 5'd2,
        FN_SBC   = 5'd3,
        FN_AND   = 5'd4,
        FN_XOR   = 5'd5,
        FN_OR    = 5'd6,
        FN_CP    = 5'd7,
        FN_INC   = 5'd8,
        FN_DEC   = 5'd9,
        FN_RLC   = 5'd10,
        FN_RRC   = 5'd11,
        FN_RL    = 5'd12,
        FN_RR    = 5'd13,
        FN_SLA   = 5'd14,
        FN_SRA   = 5'd15,
        FN_SWAP  = 5'd16,
        FN_SRL   = 5'd17,
        FN_RLCA  = 5'd18,
        FN_RRCA  = 5'd19,
        FN_RLA   = 5'd20,
        FN_RRA   = 5'd21,
        FN_DAA   = 5'd22,
        FN_SCF   = 5'd23,
        FN_CCF   = 5'd24,
        FN_ADD16 = 5'd25
    } alu_func_t;

    // Flag bit positions
    localparam int unsigned FLAG_Z = 3;
    localparam int unsigned FLAG_N = 2;
    localparam int unsigned FLAG_H = 1;
    localparam int unsigned FLAG_C = 0;

    // Decimal adjust constants
    localparam logic [7:0] DAA_HI_ADJ   = 8'h60;
    localparam logic [7:0] DAA_LO_ADJ   = 8'h06;
    localparam logic [7:0] DAA_HI_LIMIT = 8'h99;
    localparam logic [3:0] DAA_LO_LIMIT = 4'h9;

endpackage

`default_nettype wire

// ----- src/cpu_alu_with_flags_unit.sv -----
// Throughput: one operation per cycle when not stalled; an input register feeds
// the ALU logic and a result register drives the output, so each item takes one
// pass through both. A stalled output holds both stages; the input stalls only
// when both are full. Reset (rst_n low, asynchronous) empties both stages;
// payload is not cleared.
`default_nettype none

module cpu_alu_with_flags_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [4:0]  func,
    input  wire logic [15:0] operand_a,
    input  wire logic [15:0] operand_b,
    input  wire logic [3:0]  flags_in,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [15:0]      result,
    output logic [3:0]       flags_out
);

    logic                  s1_valid_reg;
    logic                  s1_valid_next;
    calu_pkg::alu_func_t   func_reg;
    logic [15:0]           a_reg;
    logic [15:0]           b_reg;
    logic [3:0]            fin_reg;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [15:0]           result_reg;
    logic [3:0]            flags_reg;

    logic                  out_free;
    logic                  s1_advance;
    logic                  in_take;
    logic [15:0]           alu_result;
    logic [3:0]            alu_flags;

    // Stage handshake: output slot frees when empty or being taken
    assign out_free   = !out_valid_reg || !out_stall;
    assign s1_advance = s1_valid_reg && out_free;
    assign in_stall   = s1_valid_reg && !out_free;
    assign in_take    = in_valid && !in_stall;

    assign s1_valid_next  = in_take || (s1_valid_reg && !out_free);
    assign out_valid_next = s1_advance || (out_valid_reg && out_stall);

    // Hold stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the operands on an input transfer
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            func_reg <= calu_pkg::alu_func_t'(func);
            a_reg    <= operand_a;
            b_reg    <= operand_b;
            fin_reg  <= flags_in;
        end
    end

    // ALU datapath
    always_comb
    begin
        logic [7:0]  a8;
        logic [7:0]  b8;
        logic        cin;
        logic        cuse;
        logic [8:0]  sum9;
        logic [4:0]  hsum5;
        logic [8:0]  diff9;
        logic [4:0]  hdiff5;
        logic [16:0] sum17;
        logic [12:0] hsum13;
        logic [7:0]  daa_adj;
        logic        daa_c;
        logic [7:0]  r8;
        logic        z_f;
        logic        n_f;
        logic        h_f;
        logic        c_f;
        logic        z_use;

        a8   = a_reg[7:0];
        b8   = b_reg[7:0];
        cin  = fin_reg[calu_pkg::FLAG_C];
        cuse = ((func_reg == calu_pkg::FN_ADC) || (func_reg == calu_pkg::FN_SBC)) ? cin : 1'b0;

        sum9   = {1'b0, a8} + {1'b0, b8} + {8'd0, cuse};
        hsum5  = {1'b0, a8[3:0]} + {1'b0, b8[3:0]} + {4'd0, cuse};
        diff9  = {1'b0, a8} - {1'b0, b8} - {8'd0, cuse};
        hdiff5 = {1'b0, a8[3:0]} - {1'b0, b8[3:0]} - {4'd0, cuse};
        sum17  = {1'b0, a_reg} + {1'b0, b_reg};
        hsum13 = {1'b0, a_reg[11:0]} + {1'b0, b_reg[11:0]};

        // Decimal adjust: pick the correction from N, H and C
        daa_adj = 8'd0;
        daa_c   = cin;
        if (!fin_reg[calu_pkg::FLAG_N])
        begin
            if (cin || (a8 > calu_pkg::DAA_HI_LIMIT))
            begin
                daa_adj = daa_adj | calu_pkg::DAA_HI_ADJ;
                daa_c   = 1'b1;
            end
            if (fin_reg[calu_pkg::FLAG_H] || (a8[3:0] > calu_pkg::DAA_LO_LIMIT))
            begin
                daa_adj = daa_adj | calu_pkg::DAA_LO_ADJ;
            end
        end
        else
        begin
            if (cin)
            begin
                daa_adj = daa_adj | calu_pkg::DAA_HI_ADJ;
            end
            if (fin_reg[calu_pkg::FLAG_H])
            begin
                daa_adj = daa_adj | calu_pkg::DAA_LO_ADJ;
            end
        end

        r8         = 8'd0;
        n_f        = 1'b0;
        h_f        = 1'b0;
        c_f        = 1'b0;
        z_use      = 1'b1;
        alu_result = 16'd0;
        alu_flags  = fin_reg;

        unique case (func_reg) inside
            calu_pkg::FN_ADD, calu_pkg::FN_ADC:
            begin
                r8  = sum9[7:0];
                h_f = hsum5[4];
                c_f = sum9[8];
            end
            calu_pkg::FN_SUB, calu_pkg::FN_SBC, calu_pkg::FN_CP:
            begin
                r8  = diff9[7:0];
                n_f = 1'b1;
                h_f = hdiff5[4];
                c_f = diff9[8];
            end
            calu_pkg::FN_AND:
            begin
                r8  = a8 & b8;
                h_f = 1'b1;
            end
            calu_pkg::FN_XOR:
            begin
                r8 = a8 ^ b8;
            end
            calu_pkg::FN_OR:
            begin
                r8 = a8 | b8;
            end
            calu_pkg::FN_INC:
            begin
                r8  = a8 + 8'd1;
                h_f = (a8[3:0] == 4'hF);
                c_f = cin;
            end
            calu_pkg::FN_DEC:
            begin
                r8  = a8 - 8'd1;
                n_f = 1'b1;
                h_f = (a8[3:0] == 4'h0);
                c_f = cin;
            end
            calu_pkg::FN_RLC, calu_pkg::FN_RLCA:
            begin
                r8    = {a8[6:0], a8[7]};
                c_f   = a8[7];
                z_use = (func_reg == calu_pkg::FN_RLC);
            end
            calu_pkg::FN_RRC, calu_pkg::FN_RRCA:
            begin
                r8    = {a8[0], a8[7:1]};
                c_f   = a8[0];
                z_use = (func_reg == calu_pkg::FN_RRC);
            end
            calu_pkg::FN_RL, calu_pkg::FN_RLA:
            begin
                r8    = {a8[6:0], cin};
                c_f   = a8[7];
                z_use = (func_reg == calu_pkg::FN_RL);
            end
            calu_pkg::FN_RR, calu_pkg::FN_RRA:
            begin
                r8    = {cin, a8[7:1]};
                c_f   = a8[0];
                z_use = (func_reg == calu_pkg::FN_RR);
            end
            calu_pkg::FN_SLA:
            begin
                r8  = {a8[6:0], 1'b0};
                c_f = a8[7];
            end
            calu_pkg::FN_SRA:
            begin
                r8  = {a8[7], a8[7:1]};
                c_f = a8[0];
            end
            calu_pkg::FN_SWAP:
            begin
                r8 = {a8[3:0], a8[7:4]};
            end
            calu_pkg::FN_SRL:
            begin
                r8  = {1'b0, a8[7:1]};
                c_f = a8[0];
            end
            calu_pkg::FN_DAA:
            begin
                r8  = fin_reg[calu_pkg::FLAG_N] ? (a8 - daa_adj) : (a8 + daa_adj);
                n_f = fin_reg[calu_pkg::FLAG_N];
                c_f = daa_c;
            end
            calu_pkg::FN_SCF, calu_pkg::FN_CCF:
            begin
                r8 = a8;
            end
            default:
            begin
                r8 = 8'd0;
            end
        endcase

        z_f = z_use && (r8 == 8'd0);

        // Assemble the result word and the flag nibble
        unique case (func_reg) inside
            calu_pkg::FN_CP:
            begin
                alu_result = a_reg;
                alu_flags  = {z_f, n_f, h_f, c_f};
            end
            calu_pkg::FN_SCF:
            begin
                alu_result = {8'd0, r8};
                alu_flags  = {fin_reg[calu_pkg::FLAG_Z], 3'b001};
            end
            calu_pkg::FN_CCF:
            begin
                alu_result = {8'd0, r8};
                alu_flags  = {fin_reg[calu_pkg::FLAG_Z], 2'b00, !cin};
            end
            calu_pkg::FN_ADD16:
            begin
                alu_result = sum17[15:0];
                alu_flags  = {fin_reg[calu_pkg::FLAG_Z], 1'b0, hsum13[12], sum17[16]};
            end
            calu_pkg::FN_ADD, calu_pkg::FN_ADC, calu_pkg::FN_SUB, calu_pkg::FN_SBC,
            calu_pkg::FN_AND, calu_pkg::FN_XOR, calu_pkg::FN_OR, calu_pkg::FN_INC,
            calu_pkg::FN_DEC, calu_pkg::FN_RLC, calu_pkg::FN_RRC, calu_pkg::FN_RL,
            calu_pkg::FN_RR, calu_pkg::FN_SLA, calu_pkg::FN_SRA, calu_pkg::FN_SWAP,
            calu_pkg::FN_SRL, calu_pkg::FN_RLCA, calu_pkg::FN_RRCA, calu_pkg::FN_RLA,
            calu_pkg::FN_RRA, calu_pkg::FN_DAA:
            begin
                alu_result = {8'd0, r8};
                alu_flags  = {z_f, n_f, h_f, c_f};
            end
            default:
            begin
                alu_result = 16'd0;
                alu_flags  = fin_reg;
            end
        endcase
    end

    // Advance the ALU output into the result register
    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            result_reg <= alu_result;
            flags_reg  <= alu_flags;
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;
    assign flags_out = flags_reg;

    // The input stalls only with both stages full and the output held
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg && out_stall))
        else $error("input stalled with a free stage");

    // An item in the ALU stage moves on when the output slot frees
    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_free) |=> out_valid_reg)
        else $error("item dropped between stages");

    // A held item in the ALU stage is kept
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !out_free) |=> (s1_valid_reg && $stable(a_reg) && $stable(b_reg)))
        else $error("held ALU stage item lost");

    // Eight-bit results never set the high byte
    a_high_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_advance && (func_reg != calu_pkg::FN_CP) && (func_reg != calu_pkg::FN_ADD16))
        |-> (alu_result[15:8] == 8'd0))
        else $error("high byte set by an 8-bit operation");

endmodule

`default_nettype wire
